FILE: sv/dq_pkg.sv
// Shared types for the double-ended queue core: operation and status codes
// and the transaction payload structs of the input and result channels.
// No dependencies.
package dq_pkg;

    typedef enum logic [1:0] {
        KIND_PUSH_FRONT = 2'd0,
        KIND_PUSH_BACK  = 2'd1,
        KIND_POP_FRONT  = 2'd2,
        KIND_POP_BACK   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned OCC_W   = 5;

    typedef struct packed {
        kind_t                      kind;
        logic signed [VALUE_W-1:0]  value;
    } in_t;

    typedef struct packed {
        status_t                    status;
        logic signed [VALUE_W-1:0]  popped;
        logic [OCC_W-1:0]           occupancy;
    } out_t;

endpackage

FILE: sv/dq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the queue storage.
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: sv/double_ended_queue_core.sv
// Double-ended queue of signed 32-bit values kept in a ring buffer RAM.
// Depends on dq_pkg and dq_ram.
//
// Usage:
//   Input channel s_valid/s_ready/s_data carries one operation per
//   transaction: push front, push back, pop front or pop back. Every
//   operation gives exactly one result transaction on m_valid/m_ready/m_data
//   with a status (ok, empty, full), the popped value (zero unless a pop
//   succeeded) and the occupancy after the operation.
//   Pushes and failed operations present their result in the cycle after
//   acceptance; a successful pop passes through ST_READ before its result
//   is registered, as the value comes from the RAM's registered read port.
//   Throughput: one push per cycle while m_ready is high; no new operation
//   is accepted while a successful pop waits in ST_READ for its read data.
//   The result register lets a new operation be accepted in the same cycle
//   that the previous result is taken.
//   Reset: head pointer and fill count clear, the queue is empty; RAM
//   contents are left as they are and never read before being written.
//   Stall: while a result waits and m_ready is low, s_ready stays low.
module double_ended_queue_core #(
    parameter int DEPTH = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  dq_pkg::in_t  s_data,
    output logic         m_valid,
    input  logic         m_ready,
    output dq_pkg::out_t m_data
);

    localparam int IDXW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam int SW   = CNTW + 1;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    state_t            state_reg, state_next;
    logic [IDXW-1:0]   head_reg, head_next;
    logic [CNTW-1:0]   count_reg, count_next;
    logic [CNTW-1:0]   pend_occ_reg, pend_occ_next;
    logic              m_valid_reg, m_valid_next;
    dq_pkg::out_t      m_data_reg, m_data_next;

    logic              accept;
    logic              out_free;
    logic              full;
    logic              empty;
    logic [IDXW-1:0]   head_dec;
    logic [IDXW-1:0]   head_inc;
    logic [CNTW-1:0]   count_inc;
    logic [CNTW-1:0]   count_dec;
    logic [CNTW-1:0]   back_off;
    logic [SW-1:0]     back_sum;
    logic [SW-1:0]     back_wrap;
    logic [IDXW-1:0]   back_pos;

    logic              wr_en;
    logic [IDXW-1:0]   wr_addr;
    logic              rd_en;
    logic [IDXW-1:0]   rd_addr;
    logic [dq_pkg::VALUE_W-1:0] rd_data;

    dq_ram #(
        .WIDTH (dq_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_data.value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign full      = (count_reg == CNTW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign head_dec  = (head_reg == '0) ? IDXW'(DEPTH - 1) : head_reg - IDXW'(1);
    assign head_inc  = (head_reg == IDXW'(DEPTH - 1)) ? '0 : head_reg + IDXW'(1);
    assign count_inc = count_reg + CNTW'(1);
    assign count_dec = count_reg - CNTW'(1);

    // back slot: head + count for a push, head + count - 1 for a pop back, mod DEPTH
    assign back_off  = (s_data.kind == dq_pkg::KIND_POP_BACK) ? count_dec : count_reg;
    assign back_sum  = SW'(head_reg) + SW'(back_off);
    assign back_wrap = (back_sum >= SW'(DEPTH)) ? back_sum - SW'(DEPTH) : back_sum;
    assign back_pos  = back_wrap[IDXW-1:0];

    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        pend_occ_next = pend_occ_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        wr_en         = 1'b0;
        wr_addr       = (s_data.kind == dq_pkg::KIND_PUSH_FRONT) ? head_dec : back_pos;
        rd_en         = 1'b0;
        rd_addr       = (s_data.kind == dq_pkg::KIND_POP_FRONT) ? head_reg : back_pos;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{status: dq_pkg::STATUS_OK, popped: '0,
                                     occupancy: dq_pkg::OCC_W'(count_reg)};
                    case (s_data.kind)
                        dq_pkg::KIND_PUSH_FRONT, dq_pkg::KIND_PUSH_BACK: begin
                            if (full) begin
                                m_data_next.status = dq_pkg::STATUS_FULL;
                            end else begin
                                wr_en                 = 1'b1;
                                count_next            = count_inc;
                                m_data_next.occupancy = dq_pkg::OCC_W'(count_inc);
                                if (s_data.kind == dq_pkg::KIND_PUSH_FRONT) begin
                                    head_next = head_dec;
                                end
                            end
                        end
                        dq_pkg::KIND_POP_FRONT, dq_pkg::KIND_POP_BACK: begin
                            if (empty) begin
                                m_data_next.status = dq_pkg::STATUS_EMPTY;
                            end else begin
                                // result waits for the RAM read data
                                m_valid_next  = 1'b0;
                                m_data_next   = m_data_reg;
                                rd_en         = 1'b1;
                                count_next    = count_dec;
                                pend_occ_next = count_dec;
                                state_next    = ST_READ;
                                if (s_data.kind == dq_pkg::KIND_POP_FRONT) begin
                                    head_next = head_inc;
                                end
                            end
                        end
                        default: begin
                            m_valid_next = m_valid_reg && !m_ready;
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{status: dq_pkg::STATUS_OK, popped: rd_data,
                                     occupancy: dq_pkg::OCC_W'(pend_occ_reg)};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        pend_occ_reg <= pend_occ_next;
        m_data_reg   <= m_data_next;
    end

endmodule

FILE: sv/dq_checker.sv
// Port-level checks for double_ended_queue_core, attached with bind.
// Depends on dq_pkg.
module dq_checker #(
    parameter int DEPTH = 16
) (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_valid,
    input logic         s_ready,
    input dq_pkg::in_t  s_data,
    input logic         m_valid,
    input logic         m_ready,
    input dq_pkg::out_t m_data
);

    // no result right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a waiting operation holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("waiting operation changed");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // failed operations return zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != dq_pkg::STATUS_OK |-> m_data.popped == '0)
        else $error("nonzero value on failed operation");

    // full and empty flags agree with occupancy
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != dq_pkg::STATUS_OK
        |-> m_data.occupancy == ((m_data.status == dq_pkg::STATUS_FULL) ?
                                 dq_pkg::OCC_W'(DEPTH) : dq_pkg::OCC_W'(0)))
        else $error("full or empty status with wrong occupancy");

endmodule

bind double_ended_queue_core dq_checker #(.DEPTH(DEPTH)) u_dq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: dv/double_ended_queue_core_test.sv
`timescale 1ns / 1ps
// Testbench for double_ended_queue_core: directed and random deque operations,
// checked against a ring-buffer predictor held in a small scoreboard class.
// Depends on dq_pkg and the double_ended_queue_core RTL.
module double_ended_queue_core_test;

    localparam int QDEPTH = 16;
    localparam int IDX_W  = $clog2(QDEPTH);

    logic         aclk;
    logic         aresetn;
    logic         s_valid;
    logic         s_ready;
    dq_pkg::in_t  s_data;
    logic         m_valid;
    logic         m_ready;
    dq_pkg::out_t m_data;

    int unsigned idle_pct;
    int unsigned stall_pct;

    // Predicts each operation's result and matches results in order.
    class dq_scoreboard;
        logic signed [dq_pkg::VALUE_W-1:0] slots[QDEPTH];
        logic [IDX_W-1:0]                  head;
        logic [dq_pkg::OCC_W-1:0]          fill;
        dq_pkg::out_t                      expected_q[$];
        int unsigned                       errors;

        function new();
            head   = '0;
            fill   = '0;
            errors = 0;
        endfunction

        function void note_input(dq_pkg::in_t op);
            dq_pkg::out_t     r;
            logic [IDX_W-1:0] pos;
            r.status    = dq_pkg::STATUS_OK;
            r.popped    = '0;
            case (op.kind)
                dq_pkg::KIND_PUSH_FRONT: begin
                    if (fill == QDEPTH) begin
                        r.status = dq_pkg::STATUS_FULL;
                    end else begin
                        head        = head - 1'b1;
                        slots[head] = op.value;
                        fill        = fill + 1'b1;
                    end
                end
                dq_pkg::KIND_PUSH_BACK: begin
                    if (fill == QDEPTH) begin
                        r.status = dq_pkg::STATUS_FULL;
                    end else begin
                        pos        = head + fill[IDX_W-1:0];
                        slots[pos] = op.value;
                        fill       = fill + 1'b1;
                    end
                end
                dq_pkg::KIND_POP_FRONT: begin
                    if (fill == 0) begin
                        r.status = dq_pkg::STATUS_EMPTY;
                    end else begin
                        r.popped = slots[head];
                        head     = head + 1'b1;
                        fill     = fill - 1'b1;
                    end
                end
                default: begin
                    if (fill == 0) begin
                        r.status = dq_pkg::STATUS_EMPTY;
                    end else begin
                        pos      = head + fill[IDX_W-1:0] - 1'b1;
                        r.popped = slots[pos];
                        fill     = fill - 1'b1;
                    end
                end
            endcase
            r.occupancy = fill;
            expected_q.push_back(r);
        endfunction

        function void check_result(dq_pkg::out_t got);
            dq_pkg::out_t exp_r;
            if (expected_q.size() == 0) begin
                $error("result transaction with no operation outstanding");
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.status !== exp_r.status) begin
                $error("status: expected %0d, actual %0d", exp_r.status, got.status);
                errors++;
            end
            if (got.popped !== exp_r.popped) begin
                $error("popped: expected %0d, actual %0d", exp_r.popped, got.popped);
                errors++;
            end
            if (got.occupancy !== exp_r.occupancy) begin
                $error("occupancy: expected %0d, actual %0d",
                       exp_r.occupancy, got.occupancy);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    dq_scoreboard sb;

    double_ended_queue_core #(
        .DEPTH(QDEPTH)
    ) uut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: check on each handshake, then pick the next ready level.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                sb.check_result(m_data);
            end
            m_ready <= aresetn && ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_op(dq_pkg::kind_t k, logic signed [dq_pkg::VALUE_W-1:0] v);
        dq_pkg::in_t op;
        op.kind  = k;
        op.value = v;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= op;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(op);
    endtask

    // Hold off the input until every outstanding result has been taken.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic signed [dq_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $urandom_range(1) ? 32'sd0 : -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random(int unsigned push_pct);
        dq_pkg::kind_t k;
        if ($urandom_range(99) < push_pct) begin
            if ($urandom_range(1) != 0) begin
                k = dq_pkg::KIND_PUSH_BACK;
            end else begin
                k = dq_pkg::KIND_PUSH_FRONT;
            end
        end else begin
            if ($urandom_range(1) != 0) begin
                k = dq_pkg::KIND_POP_BACK;
            end else begin
                k = dq_pkg::KIND_POP_FRONT;
            end
        end
        send_op(k, pick_value());
    endtask

    initial begin
        int unsigned sender_pcts[4]   = '{0, 73, 0, 19};
        int unsigned receiver_pcts[4] = '{0, 0, 73, 19};
        int unsigned push_pct;
        sb        = new();
        idle_pct  = 0;
        stall_pct = 0;
        aresetn  <= 1'b0;
        s_valid  <= 1'b0;
        s_data   <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Pops on an empty queue, then last element removed from either end.
        send_op(dq_pkg::KIND_POP_FRONT, 32'sd5);
        send_op(dq_pkg::KIND_POP_BACK, -32'sd5);
        send_op(dq_pkg::KIND_PUSH_FRONT, 32'sh8000_0000);
        send_op(dq_pkg::KIND_POP_BACK, 32'sd0);
        send_op(dq_pkg::KIND_PUSH_BACK, 32'sh7fff_ffff);
        send_op(dq_pkg::KIND_POP_FRONT, 32'sd0);
        // Fill from both ends so the head wraps, then push on a full queue.
        for (int i = 0; i < QDEPTH; i++) begin
            if (i % 2 != 0) begin
                send_op(dq_pkg::KIND_PUSH_FRONT, pick_value());
            end else begin
                send_op(dq_pkg::KIND_PUSH_BACK, pick_value());
            end
        end
        send_op(dq_pkg::KIND_PUSH_FRONT, 32'sd1);
        send_op(dq_pkg::KIND_PUSH_BACK, -32'sd1);
        send_op(dq_pkg::KIND_POP_FRONT, 32'sd0);
        send_op(dq_pkg::KIND_POP_BACK, 32'sd0);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = sender_pcts[ph];
            stall_pct = receiver_pcts[ph];
            push_pct  = 50;
            for (int n = 0; n < 500; n++) begin
                // Bias shifts every 64 transactions to sweep between empty and full.
                if (n % 64 == 0) begin
                    case ($urandom_range(2))
                        0: push_pct = 15;
                        1: push_pct = 50;
                        default: push_pct = 85;
                    endcase
                end
                send_random(push_pct);
                if ($urandom_range(199) == 0) begin
                    drain();
                end
            end
            drain();
        end

        drain();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: double_ended_queue_core.f
sv/dq_pkg.sv
sv/dq_ram.sv
sv/double_ended_queue_core.sv
sv/dq_checker.sv
dv/double_ended_queue_core_test.sv
